// ===== sv/csle_pkg.sv =====
`default_nettype none

package csle_pkg;

  typedef enum logic [2:0] {
    CMD_TICK       = 3'd0,
    CMD_RESTART    = 3'd1,
    CMD_OVR_DUR    = 3'd2,
    CMD_OVR_ENERGY = 3'd3,
    CMD_OVR_SOC    = 3'd4
  } cmd_t;

  typedef enum logic [1:0] {
    CFG_DURATION  = 2'd0,
    CFG_ENERGY    = 2'd1,
    CFG_SOC       = 2'd2,
    CFG_SOC_METER = 2'd3
  } cfg_idx_t;

  localparam logic [14:0] FULL_CURRENT_MA   = 15'd32000;
  localparam logic [3:0]  MAX_DURATION_CODE = 4'd10;
  localparam logic [6:0]  MAX_SOC_PCT       = 7'd100;
  localparam logic [31:0] TIME_HALF         = 32'h7FFF_FFFF;
  localparam logic [31:0] SAT_MAX           = 32'hFFFF_FFFF;

  // duration codes in minutes
  localparam logic [9:0] DUR_MIN [11] = '{
    10'd0, 10'd15, 10'd30, 10'd45, 10'd60, 10'd120,
    10'd180, 10'd240, 10'd360, 10'd480, 10'd720
  };

  typedef struct packed {
    logic [3:0]  dur_code;
    logic [31:0] energy_lim;
    logic [6:0]  soc_pct;
    logic        soc_meter;
  } cfg_t;

  typedef struct packed {
    logic [2:0]  cmd;
    logic        charging;
    logic [31:0] uptime_ms;
    logic [31:0] session_start_ms;
    logic        meter_start_valid;
    logic [31:0] meter_start_wh;
    logic        energy_now_valid;
    logic [31:0] energy_now_wh;
    logic        soc_valid;
    logic [9:0]  soc_tenths;
    logic [31:0] override_value;
  } in_t;

  typedef struct packed {
    logic [14:0] current_limit_ma;
    logic        limit_hit_event;
    logic [31:0] deadline_ms;
    logic [31:0] start_time_ms;
    logic        start_energy_known;
    logic [31:0] start_energy_wh;
    logic        target_energy_known;
    logic [31:0] target_energy_wh;
    logic [6:0]  shown_soc_target;
    logic [3:0]  active_duration;
    logic [31:0] active_energy;
    logic [6:0]  active_soc;
  } out_t;

endpackage

`default_nettype wire

// ===== sv/csle_cfg.sv =====
`default_nettype none

module csle_cfg (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              wr_en,
  input  wire logic [1:0]        index,
  input  wire logic [31:0]       wdata,
  output csle_pkg::cfg_t         cfg
);

  csle_pkg::cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= '0;
    end else if (wr_en) begin
      unique case (index)
        csle_pkg::CFG_DURATION: begin
          cfg_r.dur_code <= (wdata[3:0] > csle_pkg::MAX_DURATION_CODE) ?
                            csle_pkg::MAX_DURATION_CODE : wdata[3:0];
        end
        csle_pkg::CFG_ENERGY: begin
          cfg_r.energy_lim <= wdata;
        end
        csle_pkg::CFG_SOC: begin
          cfg_r.soc_pct <= (wdata[6:0] > csle_pkg::MAX_SOC_PCT) ?
                           csle_pkg::MAX_SOC_PCT : wdata[6:0];
        end
        csle_pkg::CFG_SOC_METER: begin
          cfg_r.soc_meter <= wdata[0];
        end
        default: begin
          cfg_r <= cfg_r;
        end
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule

`default_nettype wire

// ===== sv/csle_core.sv =====
`default_nettype none

module csle_core #(
  parameter int MINUTE_SECONDS = 60
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              en,
  input  wire csle_pkg::in_t     req,
  input  wire csle_pkg::cfg_t    cfg,
  output csle_pkg::out_t         res
);

  localparam logic [31:0] MS_PER_MIN = 32'(MINUTE_SECONDS * 1000);

  logic        in_session_r, in_session_nxt;
  logic        tripped_r, tripped_nxt;
  logic        stop_r, stop_nxt;
  logic [3:0]  act_dur_r, act_dur_nxt;
  logic [31:0] act_energy_r, act_energy_nxt;
  logic [6:0]  act_soc_r, act_soc_nxt;
  logic [31:0] start_time_r, start_time_nxt;
  logic [31:0] deadline_r, deadline_nxt;
  logic        start_e_ok_r, start_e_ok_nxt;
  logic [31:0] start_e_r, start_e_nxt;
  logic        tgt_ok_r, tgt_ok_nxt;
  logic [31:0] tgt_r, tgt_nxt;
  logic [6:0]  soc_shown_r, soc_shown_nxt;

  logic        event_hit;
  logic        first_tick;
  logic [3:0]  arg_code;
  logic [6:0]  arg_pct;
  logic [31:0] tick_start;
  logic        tick_e_ok;
  logic [31:0] tick_e;
  logic [3:0]  dur_code;
  logic [9:0]  dur_min;
  logic [31:0] dur_ms;
  logic [31:0] dl_base;
  logic [31:0] dl_sum;
  logic [31:0] sat_a, sat_b;
  logic [32:0] sat_raw;
  logic [31:0] sat_sum;
  logic [10:0] soc_goal;

  assign first_tick = req.charging && !in_session_r;
  assign arg_code = (req.override_value > 32'(csle_pkg::MAX_DURATION_CODE)) ?
                    csle_pkg::MAX_DURATION_CODE : req.override_value[3:0];
  assign arg_pct  = (req.override_value > 32'(csle_pkg::MAX_SOC_PCT)) ?
                    csle_pkg::MAX_SOC_PCT : req.override_value[6:0];
  assign tick_start = in_session_r ? start_time_r : req.session_start_ms;
  assign tick_e_ok  = start_e_ok_r || (first_tick && req.meter_start_valid);
  assign tick_e     = (first_tick && req.meter_start_valid) ? req.meter_start_wh : start_e_r;
  assign soc_goal   = 11'(act_soc_r) * 11'd10;

  // shared duration lookup and deadline adder
  always_comb begin
    dur_code = act_dur_r;
    dl_base  = '0;
    unique case (req.cmd)
      csle_pkg::CMD_TICK: begin
        dur_code = req.charging ? act_dur_r : cfg.dur_code;
        dl_base  = req.charging ? tick_start : '0;
      end
      csle_pkg::CMD_RESTART: begin
        dl_base = req.uptime_ms;
      end
      csle_pkg::CMD_OVR_DUR: begin
        dur_code = arg_code;
        dl_base  = start_time_r;
      end
      default: begin
        dur_code = act_dur_r;
      end
    endcase
  end

  assign dur_min = (dur_code > csle_pkg::MAX_DURATION_CODE) ? '0 : csle_pkg::DUR_MIN[dur_code];
  assign dur_ms  = 32'(32'(dur_min) * MS_PER_MIN);
  assign dl_sum  = dl_base + dur_ms;

  // shared saturating energy adder
  always_comb begin
    sat_a = tick_e;
    sat_b = act_energy_r;
    unique case (req.cmd)
      csle_pkg::CMD_RESTART: begin
        sat_a = req.energy_now_wh;
      end
      csle_pkg::CMD_OVR_ENERGY: begin
        sat_a = start_e_r;
        sat_b = req.override_value;
      end
      default: begin
        sat_a = tick_e;
      end
    endcase
  end

  assign sat_raw = {1'b0, sat_a} + {1'b0, sat_b};
  assign sat_sum = sat_raw[32] ? csle_pkg::SAT_MAX : sat_raw[31:0];

  always_comb begin
    in_session_nxt = in_session_r;
    tripped_nxt    = tripped_r;
    stop_nxt       = stop_r;
    act_dur_nxt    = act_dur_r;
    act_energy_nxt = act_energy_r;
    act_soc_nxt    = act_soc_r;
    start_time_nxt = start_time_r;
    deadline_nxt   = deadline_r;
    start_e_ok_nxt = start_e_ok_r;
    start_e_nxt    = start_e_r;
    tgt_ok_nxt     = tgt_ok_r;
    tgt_nxt        = tgt_r;
    soc_shown_nxt  = soc_shown_r;
    event_hit      = 1'b0;
    unique case (req.cmd)
      csle_pkg::CMD_TICK: begin
        stop_nxt = 1'b0;
        if (!req.charging) begin
          if (in_session_r) begin
            act_dur_nxt    = cfg.dur_code;
            act_energy_nxt = cfg.energy_lim;
            act_soc_nxt    = cfg.soc_pct;
            start_time_nxt = '0;
            start_e_ok_nxt = 1'b0;
            deadline_nxt   = dl_sum;
            tgt_ok_nxt     = 1'b0;
            soc_shown_nxt  = '0;
          end
        end else begin
          start_time_nxt = tick_start;
          start_e_ok_nxt = tick_e_ok;
          start_e_nxt    = tick_e;
          if (act_dur_r != '0) begin
            if (first_tick) begin
              deadline_nxt = dl_sum;
            end
            if (32'(req.uptime_ms - deadline_nxt) < csle_pkg::TIME_HALF) begin
              stop_nxt = 1'b1;
            end
          end
          if (act_energy_r != '0 && req.energy_now_valid) begin
            if (first_tick && tick_e_ok) begin
              tgt_nxt    = sat_sum;
              tgt_ok_nxt = 1'b1;
            end
            if (tgt_ok_nxt && tgt_nxt <= req.energy_now_wh) begin
              stop_nxt = 1'b1;
            end
          end
          if (act_soc_r != '0 && cfg.soc_meter) begin
            if (first_tick) begin
              soc_shown_nxt = act_soc_r;
            end
            if (req.soc_valid && 11'(req.soc_tenths) >= soc_goal) begin
              stop_nxt = 1'b1;
            end
          end
        end
        if (stop_nxt && !tripped_r) begin
          event_hit   = 1'b1;
          tripped_nxt = 1'b1;
        end else if (!req.charging) begin
          tripped_nxt = 1'b0;
        end
        in_session_nxt = req.charging;
      end
      csle_pkg::CMD_RESTART: begin
        if (req.charging) begin
          tripped_nxt    = 1'b0;
          start_time_nxt = req.uptime_ms;
          deadline_nxt   = dl_sum;
          if (req.energy_now_valid) begin
            start_e_nxt    = req.energy_now_wh;
            start_e_ok_nxt = 1'b1;
            tgt_nxt        = sat_sum;
            tgt_ok_nxt     = 1'b1;
          end
          soc_shown_nxt = act_soc_r;
        end
      end
      csle_pkg::CMD_OVR_DUR: begin
        tripped_nxt  = 1'b0;
        act_dur_nxt  = arg_code;
        deadline_nxt = (arg_code == '0) ? '0 : dl_sum;
      end
      csle_pkg::CMD_OVR_ENERGY: begin
        tripped_nxt    = 1'b0;
        act_energy_nxt = req.override_value;
        if (req.override_value == '0 || !start_e_ok_r) begin
          tgt_ok_nxt = 1'b0;
        end else begin
          tgt_nxt    = sat_sum;
          tgt_ok_nxt = 1'b1;
        end
      end
      csle_pkg::CMD_OVR_SOC: begin
        tripped_nxt   = 1'b0;
        act_soc_nxt   = arg_pct;
        soc_shown_nxt = arg_pct;
      end
      default: begin
        stop_nxt = stop_r;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_session_r <= 1'b0;
      tripped_r    <= 1'b0;
      stop_r       <= 1'b0;
      act_dur_r    <= '0;
      act_energy_r <= '0;
      act_soc_r    <= '0;
      start_time_r <= '0;
      deadline_r   <= '0;
      start_e_ok_r <= 1'b0;
      start_e_r    <= '0;
      tgt_ok_r     <= 1'b0;
      tgt_r        <= '0;
      soc_shown_r  <= '0;
    end else if (en) begin
      in_session_r <= in_session_nxt;
      tripped_r    <= tripped_nxt;
      stop_r       <= stop_nxt;
      act_dur_r    <= act_dur_nxt;
      act_energy_r <= act_energy_nxt;
      act_soc_r    <= act_soc_nxt;
      start_time_r <= start_time_nxt;
      deadline_r   <= deadline_nxt;
      start_e_ok_r <= start_e_ok_nxt;
      start_e_r    <= start_e_nxt;
      tgt_ok_r     <= tgt_ok_nxt;
      tgt_r        <= tgt_nxt;
      soc_shown_r  <= soc_shown_nxt;
    end
  end

  always_comb begin
    res.current_limit_ma    = stop_nxt ? '0 : csle_pkg::FULL_CURRENT_MA;
    res.limit_hit_event     = event_hit;
    res.deadline_ms         = deadline_nxt;
    res.start_time_ms       = start_time_nxt;
    res.start_energy_known  = start_e_ok_nxt;
    res.start_energy_wh     = start_e_ok_nxt ? start_e_nxt : '0;
    res.target_energy_known = tgt_ok_nxt;
    res.target_energy_wh    = tgt_ok_nxt ? tgt_nxt : '0;
    res.shown_soc_target    = soc_shown_nxt;
    res.active_duration     = act_dur_nxt;
    res.active_energy       = act_energy_nxt;
    res.active_soc          = act_soc_nxt;
  end

endmodule

`default_nettype wire

// ===== sv/charge_session_limit_enforcer.sv =====
// channel  direction  payload            handshake
// in_      input      csle_pkg::in_t     in_valid / in_stall
// out_     output     csle_pkg::out_t    out_valid / out_stall
// cfg_     input      index + 32b data   cfg_wr_en, no wait
//
// one request per cycle while no stall is raised; a request enters the input
// register, is evaluated against the session state and lands in the result
// register, which raises out_valid; out_stall can hold it in the input register
// reset is synchronous and active low, clears the state and the valid flags of both registers
// out_stall holds the result register; in_stall rises only when the input
// register is full and cannot move on
`default_nettype none

module charge_session_limit_enforcer #(
  parameter int MINUTE_SECONDS = 60
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire csle_pkg::in_t     in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output csle_pkg::out_t         out_data,
  input  wire logic              cfg_wr_en,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [31:0]       cfg_wdata
);

  logic           req_valid_r;
  csle_pkg::in_t  req_r;
  logic           out_valid_r;
  csle_pkg::out_t out_data_r;
  logic           out_free;
  logic           advance;
  csle_pkg::cfg_t cfg;
  csle_pkg::out_t res;

  assign out_free = !out_valid_r || !out_stall;
  assign advance  = req_valid_r && out_free;
  assign in_stall = req_valid_r && !out_free;

  csle_cfg u_cfg (
    .clk   (clk),
    .rst_n (rst_n),
    .wr_en (cfg_wr_en),
    .index (cfg_index),
    .wdata (cfg_wdata),
    .cfg   (cfg)
  );

  csle_core #(
    .MINUTE_SECONDS(MINUTE_SECONDS)
  ) u_core (
    .clk   (clk),
    .rst_n (rst_n),
    .en    (advance),
    .req   (req_r),
    .cfg   (cfg),
    .res   (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      req_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (!in_stall) begin
        req_valid_r <= in_valid;
      end
      if (out_free) begin
        out_valid_r <= advance;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      req_r <= in_data;
    end
    if (advance) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

`ifndef SYNTHESIS
  a_event_stops: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_data_r.limit_hit_event |-> out_data_r.current_limit_ma == '0)
    else $error("limit event without zero current");

  a_limit_codes: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (out_data_r.current_limit_ma == '0 ||
                     out_data_r.current_limit_ma == csle_pkg::FULL_CURRENT_MA))
    else $error("current limit outside the two issued values");

  a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> req_valid_r && out_valid_r)
    else $error("input stalled while pipeline has room");

  a_held_result: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_stall |=> out_valid_r && $stable(out_data_r))
    else $error("stalled result changed");
`endif

endmodule

`default_nettype wire
